FILE: hw/rtl/bcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcr_pkg: shared types and constants of the digit correction router
// Item layouts, the request record passed from front to back, register
// indexes and the small digit arithmetic helpers.
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int unsigned NUM_LVL   = 4;   // levels addressable by a 2-bit level
  localparam int unsigned ID_W      = 16;
  localparam int unsigned SW_W      = 12;
  localparam int unsigned DIG_W     = 4;   // base up to 16
  localparam int unsigned WT_W      = 13;  // n^k for k <= 3, n <= 16
  localparam int unsigned ACC_W     = 17;  // n^(k+1) and digit-weight sums
  localparam int unsigned BASE_W    = 5;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [BASE_W-1:0] BASE_MIN  = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX  = 5'd16;
  localparam logic [BASE_W-1:0] PORTS_RST = 5'd4;
  localparam logic [LVL_W-1:0]  TOP_RST   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PORTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 1'd1;

  typedef logic [DIG_W-1:0] digit_t;
  typedef logic [WT_W-1:0]  weight_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    K_ROUTE = 3'b001,
    K_EQUAL = 3'b010,
    K_ERROR = 3'b100
  } req_kind_t;

  typedef struct packed {
    logic [ID_W-1:0] source_server;
    logic [ID_W-1:0] dest_server;
    logic [LVL_W-1:0] start_level;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] from_server;
    logic [SW_W-1:0] switch_idx;
    logic [LVL_W-1:0] hop_level;
    logic [ID_W-1:0] to_server;
    logic hop_valid;
    logic range_error;
    logic last_hop;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]          src;
    digit_t [NUM_LVL-1:0]     cur;
    digit_t [NUM_LVL-1:0]     dd;
    weight_t [NUM_LVL-1:0]    wt;
    logic [LVL_W-1:0]         start;
    logic [LVL_W-1:0]         top;
    req_kind_t                kind;
  } req_t;

  function automatic acc_t mul_dw(digit_t dig, weight_t wt);
    mul_dw = ACC_W'(dig) * ACC_W'(wt);
  endfunction

  // largest digit d with d * wt <= rem; compares run side by side
  function automatic digit_t digit_of(logic [ID_W-1:0] rem, weight_t wt);
    digit_t dig;
    dig = '0;
    for (int d = 1; d < (1 << DIG_W); d++) begin
      if (mul_dw(DIG_W'(d), wt) <= ACC_W'(rem)) begin
        dig = DIG_W'(d);
      end
    end
    digit_of = dig;
  endfunction

endpackage

FILE: hw/rtl/bcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcr_front: request intake and classification
// Captures a request, builds the level weights n^L, range checks the ids and
// splits both ids into digits, most significant level first.
// ----------------------------------------------------------------------------
module bcr_front #(
  parameter int unsigned MAX_LEVELS  = 4,
  parameter int unsigned SERVER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bcr_pkg::in_item_t              in_data,
  input  logic [bcr_pkg::BASE_W-1:0]     cfg_ports,
  input  logic [bcr_pkg::LVL_W-1:0]      cfg_top,
  output logic                           q_push,
  output bcr_pkg::req_t                  q_wdata,
  input  logic                           q_full
);
  import bcr_pkg::*;

  localparam int unsigned LVL_CAP  = (MAX_LEVELS > NUM_LVL) ? NUM_LVL : MAX_LEVELS;
  localparam logic [LVL_W-1:0] TOP_CAP = LVL_W'(LVL_CAP - 1);
  localparam int unsigned CAP_BITS = (SERVER_BITS < ID_W) ? SERVER_BITS : ID_W;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((33'd1 << CAP_BITS) - 33'd1);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_POW   = 5'b00010,
    F_CHECK = 5'b00100,
    F_SPLIT = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [ID_W-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [LVL_W-1:0] start_r, start_nxt, top_r, top_nxt, idx_r, idx_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  acc_t pow_r, pow_nxt;
  weight_t [NUM_LVL-1:0] wt_r, wt_nxt;
  logic [ID_W-1:0] rs_r, rs_nxt, rd_r, rd_nxt;
  digit_t [NUM_LVL-1:0] cur_r, cur_nxt, dd_r, dd_nxt;
  req_kind_t kind_r, kind_nxt;

  logic in_acc;
  logic bad;
  digit_t dig_s, dig_d;

  assign in_stall = !rst_n || (state_r != F_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign dig_s = digit_of(rs_r, wt_r[idx_r]);
  assign dig_d = digit_of(rd_r, wt_r[idx_r]);

  assign bad = (ACC_W'(src_r) >= pow_r) || (ACC_W'(dst_r) >= pow_r) ||
               (start_r > top_r) || (|((src_r | dst_r) & ~ID_MASK));

  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    start_nxt = start_r;
    top_nxt   = top_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    pow_nxt   = pow_r;
    wt_nxt    = wt_r;
    rs_nxt    = rs_r;
    rd_nxt    = rd_r;
    cur_nxt   = cur_r;
    dd_nxt    = dd_r;
    kind_nxt  = kind_r;
    case (state_r)
      F_IDLE: begin
        if (in_acc) begin
          src_nxt   = in_data.source_server;
          dst_nxt   = in_data.dest_server;
          start_nxt = in_data.start_level;
          base_nxt  = (cfg_ports < BASE_MIN) ? BASE_MIN :
                      (cfg_ports > BASE_MAX) ? BASE_MAX : cfg_ports;
          top_nxt   = (cfg_top > TOP_CAP) ? TOP_CAP : cfg_top;
          idx_nxt   = '0;
          pow_nxt   = ACC_W'(1);
          wt_nxt    = '0;
          cur_nxt   = '0;
          dd_nxt    = '0;
          state_nxt = F_POW;
        end
      end
      F_POW: begin
        // one weight a cycle; pow ends at n^(k+1)
        wt_nxt[idx_r] = pow_r[WT_W-1:0];
        pow_nxt       = pow_r * ACC_W'(base_r);
        if (idx_r == top_r) begin
          state_nxt = F_CHECK;
        end else begin
          idx_nxt = idx_r + LVL_W'(1);
        end
      end
      F_CHECK: begin
        if (bad) begin
          kind_nxt  = K_ERROR;
          state_nxt = F_PUSH;
        end else if (src_r == dst_r) begin
          kind_nxt  = K_EQUAL;
          state_nxt = F_PUSH;
        end else begin
          kind_nxt  = K_ROUTE;
          rs_nxt    = src_r;
          rd_nxt    = dst_r;
          idx_nxt   = top_r;
          state_nxt = F_SPLIT;
        end
      end
      F_SPLIT: begin
        // one digit of each id a cycle, top level down
        cur_nxt[idx_r] = dig_s;
        dd_nxt[idx_r]  = dig_d;
        rs_nxt = rs_r - ID_W'(mul_dw(dig_s, wt_r[idx_r]));
        rd_nxt = rd_r - ID_W'(mul_dw(dig_d, wt_r[idx_r]));
        if (idx_r == '0) begin
          state_nxt = F_PUSH;
        end else begin
          idx_nxt = idx_r - LVL_W'(1);
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    start_r <= start_nxt;
    top_r   <= top_nxt;
    idx_r   <= idx_nxt;
    base_r  <= base_nxt;
    pow_r   <= pow_nxt;
    wt_r    <= wt_nxt;
    rs_r    <= rs_nxt;
    rd_r    <= rd_nxt;
    cur_r   <= cur_nxt;
    dd_r    <= dd_nxt;
    kind_r  <= kind_nxt;
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    q_wdata       = '0;
    q_wdata.src   = src_r;
    q_wdata.cur   = cur_r;
    q_wdata.dd    = dd_r;
    q_wdata.wt    = wt_r;
    q_wdata.start = start_r;
    q_wdata.top   = top_r;
    q_wdata.kind  = kind_r;
  end

  // a checked id never yields a digit at or above the base
  a_digit_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_SPLIT |-> ({1'b0, dig_s} < base_r) && ({1'b0, dig_d} < base_r))
    else $error("digit split produced a digit outside the base");

  // a route request leaves the split with both ids fully consumed
  a_split_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_PUSH && kind_r == K_ROUTE |-> rs_r == '0 && rd_r == '0)
    else $error("digit split left a remainder");

endmodule

FILE: hw/rtl/bcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcr_queue: request queue between front and back
// Two-entry first-in first-out store of classified requests.
// ----------------------------------------------------------------------------
module bcr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bcr_pkg::req_t wdata,
  output logic          full,
  input  logic          pop,
  output bcr_pkg::req_t rdata,
  output logic          empty
);
  import bcr_pkg::*;

  req_t ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/bcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcr_back: hop generation
// Walks the levels from the start level downwards, wrapping at zero, and for
// each differing digit builds one hop by accumulating the switch id and the
// corrected server id one level a cycle.
// ----------------------------------------------------------------------------
module bcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  bcr_pkg::req_t      q_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output bcr_pkg::out_item_t out_data
);
  import bcr_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SCAN = 4'b0010,
    B_ACC  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [ID_W-1:0] from_r, from_nxt;
  digit_t [NUM_LVL-1:0] cur_r, cur_nxt, dd_r, dd_nxt;
  weight_t [NUM_LVL-1:0] wt_r, wt_nxt;
  logic [LVL_W-1:0] top_r, top_nxt, lvl_r, lvl_nxt, l_r, l_nxt;
  logic [NUM_LVL-1:0] rem_r, rem_nxt;
  acc_t sw_acc_r, sw_acc_nxt, to_acc_r, to_acc_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic out_load;
  logic [LVL_W-1:0] lvl_step;
  logic [NUM_LVL-1:0] diff_mask, rem_clr;
  weight_t sw_wt;
  acc_t sw_sum, to_sum;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_load = (state_r == B_EMIT) && (!out_valid_r || !out_stall);
  assign lvl_step = (lvl_r == '0) ? top_r : lvl_r - LVL_W'(1);

  always_comb begin
    for (int l = 0; l < NUM_LVL; l++) begin
      diff_mask[l] = (LVL_W'(l) <= q_rdata.top) && (q_rdata.cur[l] != q_rdata.dd[l]);
    end
    rem_clr        = rem_r;
    rem_clr[lvl_r] = 1'b0;
  end

  // switch weight: levels above the hop level move down one place
  always_comb begin
    if (l_r < lvl_r) begin
      sw_wt = wt_r[l_r];
    end else if (l_r > lvl_r) begin
      sw_wt = wt_r[l_r - LVL_W'(1)];
    end else begin
      sw_wt = '0;
    end
  end

  assign sw_sum = sw_acc_r + mul_dw(cur_r[l_r], sw_wt);
  assign to_sum = to_acc_r + mul_dw((l_r == lvl_r) ? dd_r[l_r] : cur_r[l_r], wt_r[l_r]);

  always_comb begin
    state_nxt  = state_r;
    from_nxt   = from_r;
    cur_nxt    = cur_r;
    dd_nxt     = dd_r;
    wt_nxt     = wt_r;
    top_nxt    = top_r;
    lvl_nxt    = lvl_r;
    l_nxt      = l_r;
    rem_nxt    = rem_r;
    sw_acc_nxt = sw_acc_r;
    to_acc_nxt = to_acc_r;
    res_nxt    = res_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          res_nxt = '0;
          case (q_rdata.kind)
            K_ROUTE: begin
              from_nxt  = q_rdata.src;
              cur_nxt   = q_rdata.cur;
              dd_nxt    = q_rdata.dd;
              wt_nxt    = q_rdata.wt;
              top_nxt   = q_rdata.top;
              lvl_nxt   = q_rdata.start;
              rem_nxt   = diff_mask;
              state_nxt = B_SCAN;
            end
            K_EQUAL: begin
              res_nxt.from_server = q_rdata.src;
              res_nxt.to_server   = q_rdata.src;
              res_nxt.hop_level   = q_rdata.start;
              res_nxt.last_hop    = 1'b1;
              state_nxt           = B_EMIT;
            end
            default: begin
              res_nxt.range_error = 1'b1;
              res_nxt.last_hop    = 1'b1;
              state_nxt           = B_EMIT;
            end
          endcase
        end
      end
      B_SCAN: begin
        if (rem_r[lvl_r]) begin
          l_nxt      = '0;
          sw_acc_nxt = '0;
          to_acc_nxt = '0;
          state_nxt  = B_ACC;
        end else begin
          lvl_nxt = lvl_step;
        end
      end
      B_ACC: begin
        sw_acc_nxt = sw_sum;
        to_acc_nxt = to_sum;
        if (l_r == top_r) begin
          res_nxt.from_server = from_r;
          res_nxt.switch_idx  = sw_sum[SW_W-1:0];
          res_nxt.hop_level   = lvl_r;
          res_nxt.to_server   = to_sum[ID_W-1:0];
          res_nxt.hop_valid   = 1'b1;
          res_nxt.range_error = 1'b0;
          res_nxt.last_hop    = (rem_clr == '0);
          cur_nxt[lvl_r]      = dd_r[lvl_r];
          from_nxt            = to_sum[ID_W-1:0];
          rem_nxt             = rem_clr;
          lvl_nxt             = lvl_step;
          state_nxt           = B_EMIT;
        end else begin
          l_nxt = l_r + LVL_W'(1);
        end
      end
      B_EMIT: begin
        if (out_load) begin
          state_nxt = res_r.last_hop ? B_IDLE : B_SCAN;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_load ? res_r : out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r     <= from_nxt;
    cur_r      <= cur_nxt;
    dd_r       <= dd_nxt;
    wt_r       <= wt_nxt;
    top_r      <= top_nxt;
    lvl_r      <= lvl_nxt;
    l_r        <= l_nxt;
    rem_r      <= rem_nxt;
    sw_acc_r   <= sw_acc_nxt;
    to_acc_r   <= to_acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a hop is only built at a level whose digit still differs
  a_hop_level_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ACC |-> rem_r[lvl_r])
    else $error("hop built at a level with no pending correction");

  // once a hop is built its level carries the destination digit
  a_digit_corrected: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ACC && l_r == top_r |=> cur_r[$past(lvl_r)] == dd_r[$past(lvl_r)])
    else $error("hop level digit not corrected");

  // the last flag of a real hop matches the pending level mask
  a_last_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT && res_r.hop_valid |-> res_r.last_hop == (rem_r == '0))
    else $error("last hop flag disagrees with pending levels");

  // a rejected request gives a single result and no hop
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.range_error |-> !out_data_r.hop_valid && out_data_r.last_hop)
    else $error("rejected request result malformed");

endmodule

FILE: hw/rtl/bcube_digit_correction_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcube_digit_correction_router: source route builder for a BCube fabric
// Turns a source/destination server pair into the list of hops that corrects
// one address digit per level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one item is a request of
//   source server, destination server and start level. Output channel
//   (out_valid / out_stall / out_data): one to four items per request, the
//   final one carrying last_hop. Rejected and same-server requests give one
//   item each.
//   cfg_we / cfg_index / cfg_wdata write the base (ports per switch) and the
//   top level; write them only while no request is in flight.
// Processing steps, with k the effective top level:
//   front: intake, k+1 power steps, check, k+1 digit steps for a routed
//   request, hand-over; a rejected or same-server one skips the digit steps;
//   each step is one pass of the weight multiplier or the digit comparators.
//   back: a rejected or same-server request goes straight from intake to
//   emit; a route scans the levels and builds each hop by accumulating the
//   switch id one level a cycle. A two-entry queue lets the front classify
//   the next request while the back emits hops.
// Reset: rst_n is synchronous; it empties front, queue and back and loads
//   base 4 and top level 1. in_stall is held high during reset.
// Receiver stall: the output register holds its item; the back and then
//   the queue and front fill up and in_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module bcube_digit_correction_router #(
  parameter int unsigned MAX_LEVELS  = 4,
  parameter int unsigned SERVER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcr_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcr_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [bcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcr_pkg::BASE_W-1:0]      cfg_wdata
);
  import bcr_pkg::*;

  // configuration registers
  logic [BASE_W-1:0] ports_r, ports_nxt;
  logic [LVL_W-1:0]  top_r, top_nxt;

  // front to queue, queue to back
  logic q_push, q_full, q_pop, q_empty;
  req_t q_wdata, q_rdata;

  always_comb begin
    ports_nxt = ports_r;
    top_nxt   = top_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PORTS: ports_nxt = cfg_wdata;
        REG_TOP:   top_nxt   = cfg_wdata[LVL_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r <= PORTS_RST;
      top_r   <= TOP_RST;
    end else begin
      ports_r <= ports_nxt;
      top_r   <= top_nxt;
    end
  end

  // classify and split the request into digits
  bcr_front #(
    .MAX_LEVELS  (MAX_LEVELS),
    .SERVER_BITS (SERVER_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_ports (ports_r),
    .cfg_top   (top_r),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  // hold classified requests until the back is free
  bcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // emit the hops, one output item at a time
  bcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
